>>> hw/rtl/sparse_weight_dot_and_update_defines.svh
// Assertion macros for the sparse weight dot and update block.
// Used by sparse_weight_dot_and_update.sv; needs clk and arst_n in scope.
`ifndef SPARSE_WEIGHT_DOT_AND_UPDATE_DEFINES_SVH
`define SPARSE_WEIGHT_DOT_AND_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SWDU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swdu check failed");
// next-cycle implication
`define SWDU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swdu check failed");
`else
`define SWDU_ASSERT_IMP(lbl, ante, cons)
`define SWDU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/swdu_pkg.sv
// Package for the sparse weight dot and update block: payload types,
// command codes and fixed-point constants. No dependencies.
`timescale 1ns / 1ps
package swdu_pkg;

	localparam int unsigned WEIGHT_DEPTH = 4096;
	localparam int unsigned ADDR_W       = $clog2(WEIGHT_DEPTH);
	localparam int unsigned FRAC_BITS    = 16;
	localparam int unsigned IDX_W        = 12;

	// command codes; 5..7 are ignored
	localparam logic [2:0] CMD_WRITE  = 3'd0;
	localparam logic [2:0] CMD_READ   = 3'd1;
	localparam logic [2:0] CMD_DOT    = 3'd2;
	localparam logic [2:0] CMD_UPDATE = 3'd3;
	localparam logic [2:0] CMD_SCALE  = 3'd4;

	// saturation bounds on the 65-bit sum
	localparam logic signed [64:0] ACC_MAX = 65'sd140737488355327;
	localparam logic signed [64:0] ACC_MIN = -65'sd140737488355328;
	localparam logic signed [64:0] W_MAX   = 65'sd2147483647;
	localparam logic signed [64:0] W_MIN   = -65'sd2147483648;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [IDX_W-1:0]   index;
		logic signed [31:0] value;
		logic signed [31:0] scale_factor;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic               is_dot;
		logic               saturated;
	} res_t;

endpackage

>>> hw/rtl/sparse_weight_dot_and_update.sv
// Sparse weight store with dot product, axpy update and scale.
// Top level; depends on swdu_pkg and sparse_weight_dot_and_update_defines.svh.
//
// Usage:
//   item channel (item_valid / item_stall / item) carries one command per
//   transaction: write, read, dot element, update element, scale weight.
//   result channel (result_valid / result_stall / res) returns the weight for
//   a read and the saturated Q16.16 sum for a dot element marked last.
//   Weights live in a 4096 x 32 synchronous RAM; each item reads its weight,
//   multiplies (one 32x32 multiplier), then commits in a read-modify-write.
//   An item passes through three steps (RAM read, multiply, commit), and no
//   new item is taken until the last one commits; item_stall is high while
//   an item is in flight. result_valid is set when its item's commit completes.
//   The result sits in an output register; while it is stalled the next item
//   is still taken, and only an item that itself produces a result waits in
//   its commit cycle until the register frees up.
//   Reset clears the sequencer state, the accumulator, the saturation flag and the output valid.
//   Weight RAM contents are undefined until written; there is no clear pass.
`timescale 1ns / 1ps
`include "sparse_weight_dot_and_update_defines.svh"
module sparse_weight_dot_and_update (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  swdu_pkg::item_t item,
	output logic            result_valid,
	input  logic            result_stall,
	output swdu_pkg::res_t  res
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MULT = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	state_t                   state_q;
	swdu_pkg::item_t          op_q;
	logic signed [31:0]       rdata_q;
	logic signed [63:0]       prod_q;
	logic signed [47:0]       acc_q;
	logic                     sat_seen_q;
	logic                     res_valid_q;
	swdu_pkg::res_t           res_q;

	logic signed [31:0] mem [swdu_pkg::WEIGHT_DEPTH];

	logic                     accept;
	logic                     idx_ok;
	logic signed [31:0]       weight;
	logic signed [31:0]       mul_a;
	logic signed [31:0]       mul_b;
	logic signed [63:0]       shifted;
	logic signed [64:0]       addend;
	logic signed [64:0]       sum;
	logic signed [47:0]       acc_next;
	logic                     acc_flag;
	logic signed [31:0]       dot_res;
	logic                     fin_flag;
	logic signed [31:0]       w_new;
	logic                     needs_res;
	logic                     go;
	logic                     mem_we;
	logic signed [31:0]       mem_wdata;
	logic signed [64:0]       acc_ext;

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = res_valid_q;
	assign res          = res_q;

	// weight operand, zero past the end of the store
	assign idx_ok = ({1'b0, op_q.index} < (swdu_pkg::IDX_W + 1)'(swdu_pkg::WEIGHT_DEPTH));
	assign weight = idx_ok ? rdata_q : 32'sd0;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = (op_q.cmd == swdu_pkg::CMD_SCALE) ? weight : op_q.value;
		mul_b = (op_q.cmd == swdu_pkg::CMD_DOT) ? weight : op_q.scale_factor;
	end

	// commit: one add, then saturate
	always_comb begin
		shifted = prod_q >>> swdu_pkg::FRAC_BITS;
		case (op_q.cmd)
			swdu_pkg::CMD_DOT:    addend = 65'(acc_q);
			swdu_pkg::CMD_UPDATE: addend = 65'(weight);
			default:              addend = '0;
		endcase
		sum = addend + 65'(shifted);

		acc_flag = 1'b0;
		if (sum > swdu_pkg::ACC_MAX) begin
			acc_next = swdu_pkg::ACC_MAX[47:0];
			acc_flag = 1'b1;
		end else if (sum < swdu_pkg::ACC_MIN) begin
			acc_next = swdu_pkg::ACC_MIN[47:0];
			acc_flag = 1'b1;
		end else begin
			acc_next = sum[47:0];
		end

		acc_ext  = 65'(acc_next);
		fin_flag = 1'b0;
		if (acc_ext > swdu_pkg::W_MAX) begin
			dot_res  = swdu_pkg::W_MAX[31:0];
			fin_flag = 1'b1;
		end else if (acc_ext < swdu_pkg::W_MIN) begin
			dot_res  = swdu_pkg::W_MIN[31:0];
			fin_flag = 1'b1;
		end else begin
			dot_res = acc_next[31:0];
		end

		if (sum > swdu_pkg::W_MAX)
			w_new = swdu_pkg::W_MAX[31:0];
		else if (sum < swdu_pkg::W_MIN)
			w_new = swdu_pkg::W_MIN[31:0];
		else
			w_new = sum[31:0];
	end

	// commit handshake and write-back
	always_comb begin
		needs_res = (op_q.cmd == swdu_pkg::CMD_READ) ||
			((op_q.cmd == swdu_pkg::CMD_DOT) && op_q.last);
		go = (state_q == ST_EXEC) && (!needs_res || !res_valid_q || !result_stall);
		mem_we = 1'b0;
		mem_wdata = w_new;
		case (op_q.cmd)
			swdu_pkg::CMD_WRITE: begin
				mem_we    = go && idx_ok;
				mem_wdata = op_q.value;
			end
			swdu_pkg::CMD_UPDATE,
			swdu_pkg::CMD_SCALE: begin
				mem_we = go && idx_ok;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// weight RAM, read registered when an item is accepted
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[op_q.index[swdu_pkg::ADDR_W-1:0]] <= mem_wdata;
		if (accept)
			rdata_q <= mem[item.index[swdu_pkg::ADDR_W-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept)
			op_q <= item;
		if (state_q == ST_MULT)
			prod_q <= mul_a * mul_b;
		if (go && needs_res) begin
			if (op_q.cmd == swdu_pkg::CMD_DOT) begin
				res_q.result    <= dot_res;
				res_q.is_dot    <= 1'b1;
				res_q.saturated <= sat_seen_q || acc_flag || fin_flag;
			end else begin
				res_q.result    <= weight;
				res_q.is_dot    <= 1'b0;
				res_q.saturated <= 1'b0;
			end
		end
	end

	// control: sequencer, accumulator, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			sat_seen_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_MULT;
				ST_MULT: state_q <= ST_EXEC;
				ST_EXEC: if (go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase

			if (go && (op_q.cmd == swdu_pkg::CMD_DOT)) begin
				if (op_q.last) begin
					acc_q      <= '0;
					sat_seen_q <= 1'b0;
				end else begin
					acc_q      <= acc_next;
					sat_seen_q <= sat_seen_q || acc_flag;
				end
			end

			if (go && needs_res)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	// checks
	`SWDU_ASSERT_NXT(a_accept_to_mult, accept, state_q == ST_MULT)
	`SWDU_ASSERT_NXT(a_exec_holds,
		(state_q == ST_EXEC) && needs_res && res_valid_q && result_stall,
		state_q == ST_EXEC)
	`SWDU_ASSERT_IMP(a_valid_from_exec, $rose(res_valid_q), $past(state_q) == ST_EXEC)
	`SWDU_ASSERT_NXT(a_dot_clears,
		go && (op_q.cmd == swdu_pkg::CMD_DOT) && op_q.last,
		(acc_q == 48'sd0) && !sat_seen_q)

endmodule
